// ----- rtl/psfc_pkg.sv -----
// ----------------------------------------------------------------------------
// psfc_pkg
// Shared types, codes and parse step functions of the plot stream format
// classifier.
// ----------------------------------------------------------------------------
package psfc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam logic [15:0] MAX_BLOCK_COUNT_RESET = 16'd32766;

   // front pairing phase
   localparam logic [1:0] FP_FIRST  = 2'd0;
   localparam logic [1:0] FP_SECOND = 2'd1;
   localparam logic [1:0] FP_RUN    = 2'd2;

   // back parse phase
   localparam logic [3:0] PH_SYNC  = 4'd2;
   localparam logic [3:0] PH_MARK  = 4'd3;
   localparam logic [3:0] PH_TYPE  = 4'd4;
   localparam logic [3:0] PH_FSC   = 4'd5;
   localparam logic [3:0] PH_COUNT = 4'd6;
   localparam logic [3:0] PH_EOF   = 4'd7;
   localparam logic [3:0] PH_CMD   = 4'd8;
   localparam logic [3:0] PH_SKIP  = 4'd9;

   // format codes
   localparam logic [2:0] FMT_VECTOR    = 3'd0;
   localparam logic [2:0] FMT_RASTER1D  = 3'd1;
   localparam logic [2:0] FMT_BLOCKED   = 3'd4;
   localparam logic [2:0] FMT_PACKED16  = 3'd5;
   localparam logic [2:0] FMT_PACKED32  = 3'd6;
   localparam logic [2:0] FMT_GFX_LANG  = 3'd7;

   // error codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_SYNC      = 4'd1;
   localparam logic [3:0] ERR_HEADER    = 4'd2;
   localparam logic [3:0] ERR_SYNC_CONT = 4'd3;
   localparam logic [3:0] ERR_COUNT     = 4'd4;
   localparam logic [3:0] ERR_END_COUNT = 4'd5;
   localparam logic [3:0] ERR_COMMAND   = 4'd6;
   localparam logic [3:0] ERR_SPLIT     = 4'd7;
   localparam logic [3:0] ERR_EARLY_END = 4'd8;

   // header and command constants
   localparam logic [7:0]  BLOCK_MARK     = 8'h18;
   localparam logic [7:0]  SWAP_LEAD      = 8'h01;
   localparam logic [7:0]  HDR_FSC        = 8'h01;
   localparam logic [7:0]  HDR_COUNT      = 8'h02;
   localparam logic [7:0]  HDR_EOF        = 8'h03;
   localparam logic [15:0] FSC_MID_WORD   = 16'h1802;
   localparam logic [15:0] COUNT_ALL_ONES = 16'hffff;

   localparam logic [7:0] CMD_VECTOR  = 8'h80;
   localparam logic [7:0] CMD_RASTER  = 8'h81;
   localparam logic [7:0] CMD_BLOCKED = 8'h82;
   localparam logic [7:0] CMD_PACK16  = 8'h83;
   localparam logic [7:0] CMD_PACK32  = 8'h84;
   localparam logic [7:0] CMD_OPND_C0 = 8'hc0;
   localparam logic [7:0] CMD_OPND_C5 = 8'hc5;
   localparam logic [7:0] CMD_OPND_C6 = 8'hc6;
   localparam logic [7:0] CMD_OPND_CC = 8'hcc;
   localparam logic [7:0] CMD_IDLE_C2 = 8'hc2;
   localparam logic [7:0] CMD_IDLE_C3 = 8'hc3;
   localparam logic [7:0] CMD_IDLE_C4 = 8'hc4;

   localparam logic [7:0] SYNC_PATTERN [8] = '{
      8'h18, 8'h01, 8'h00, 8'h00, 8'h18, 8'h02, 8'h00, 8'h00
   };

   // one queue slot: up to two parsed bytes from one accepted beat
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [1:0] count;
      logic       last;
      logic       swap;
   } queue_entry_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [2:0]  sync_index;
      logic [2:0]  header_step;
      logic [15:0] block_left;
      logic [15:0] cmd;
      logic [7:0]  word_hi;
      logic        decided;
      logic [2:0]  res_fmt;
      logic [3:0]  res_err;
   } back_state_type;

   localparam back_state_type BACK_RESET = '{phase: PH_SYNC, default: '0};

   function automatic back_state_type finish(back_state_type s, logic [2:0] fmt,
                                             logic [3:0] err);
      back_state_type n;
      n = s;
      n.decided = 1'b1;
      n.res_fmt = fmt;
      n.res_err = err;
      return n;
   endfunction

   function automatic back_state_type settle(back_state_type s);
      back_state_type n;
      n = s;
      if (s.block_left == 16'd0) begin
         n.phase = PH_MARK;
      end else if (s.cmd[7:0] == 8'd0) begin
         if (s.block_left == 16'd1) begin
            n = finish(s, FMT_VECTOR, ERR_SPLIT);
         end else begin
            n.phase = PH_CMD;
            n.header_step = 3'd0;
         end
      end else begin
         n.phase = PH_SKIP;
      end
      return n;
   endfunction

   function automatic back_state_type run_command(back_state_type s);
      back_state_type n;
      logic [7:0] hi;
      logic [7:0] lo;
      n = s;
      hi = s.cmd[15:8];
      lo = s.cmd[7:0];
      case (hi)
         CMD_VECTOR:  n = finish(s, FMT_VECTOR, ERR_NONE);
         CMD_RASTER: begin
            if (lo <= 8'd2) n = finish(s, FMT_RASTER1D + {1'b0, lo[1:0]}, ERR_NONE);
            else n = finish(s, FMT_VECTOR, ERR_COMMAND);
         end
         CMD_BLOCKED: n = finish(s, FMT_BLOCKED, ERR_NONE);
         CMD_PACK16:  n = finish(s, FMT_PACKED16, ERR_NONE);
         CMD_PACK32:  n = finish(s, FMT_PACKED32, ERR_NONE);
         CMD_OPND_C0, CMD_OPND_C5, CMD_OPND_C6, CMD_OPND_CC: n = settle(s);
         CMD_IDLE_C2, CMD_IDLE_C3, CMD_IDLE_C4: begin
            if (lo != 8'd0) n = finish(s, FMT_VECTOR, ERR_COMMAND);
            else n = settle(s);
         end
         default: n = finish(s, FMT_VECTOR, ERR_COMMAND);
      endcase
      return n;
   endfunction

   // one parsed byte through the frame and block parser
   function automatic back_state_type feed(back_state_type s, logic [7:0] b,
                                           logic [15:0] max_count);
      back_state_type n;
      logic [15:0] w;
      n = s;
      w = {s.word_hi, b};
      if (!s.decided) begin
         case (s.phase)
            PH_SYNC: begin
               if (b != SYNC_PATTERN[s.sync_index]) begin
                  n = finish(s, FMT_VECTOR, ERR_SYNC);
               end else if (s.sync_index == 3'd7) begin
                  n.sync_index = 3'd0;
                  n.phase = PH_MARK;
               end else begin
                  n.sync_index = s.sync_index + 3'd1;
               end
            end
            PH_MARK: begin
               if (b != BLOCK_MARK) n = finish(s, FMT_VECTOR, ERR_HEADER);
               else n.phase = PH_TYPE;
            end
            PH_TYPE: begin
               n.header_step = 3'd0;
               if (b == HDR_FSC) n.phase = PH_FSC;
               else if (b == HDR_COUNT) n.phase = PH_COUNT;
               else if (b == HDR_EOF) n.phase = PH_EOF;
               else n = finish(s, FMT_VECTOR, ERR_HEADER);
            end
            PH_SKIP: begin
               n.cmd = s.cmd - 16'd1;
               n.block_left = s.block_left - 16'd1;
               n = settle(n);
            end
            PH_FSC, PH_COUNT, PH_EOF, PH_CMD: begin
               if (!s.header_step[0]) begin
                  n.word_hi = b;
                  n.header_step = s.header_step + 3'd1;
               end else begin
                  case (s.phase)
                     PH_FSC: begin
                        if (w != ((s.header_step == 3'd3) ? FSC_MID_WORD : 16'd0)) begin
                           n = finish(s, FMT_VECTOR, ERR_SYNC_CONT);
                        end else if (s.header_step >= 3'd5) begin
                           n.header_step = 3'd0;
                           n.phase = PH_MARK;
                        end else begin
                           n.header_step = s.header_step + 3'd1;
                        end
                     end
                     PH_COUNT: begin
                        n.header_step = 3'd0;
                        if (w == COUNT_ALL_ONES) begin
                           n = finish(n, FMT_GFX_LANG, ERR_NONE);
                        end else if (w > max_count) begin
                           n = finish(n, FMT_VECTOR, ERR_COUNT);
                        end else begin
                           n.block_left = w;
                           n = settle(n);
                        end
                     end
                     PH_EOF: begin
                        n.header_step = 3'd0;
                        if (w != 16'd0) begin
                           n = finish(n, FMT_VECTOR, ERR_END_COUNT);
                        end else begin
                           n.sync_index = 3'd0;
                           n.phase = PH_SYNC;
                        end
                     end
                     default: begin
                        n.header_step = 3'd0;
                        n.cmd = w;
                        n.block_left = s.block_left - 16'd2;
                        n = run_command(n);
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
      return n;
   endfunction

endpackage

// ----- rtl/plot_stream_format_classifier_core.sv -----
// ----------------------------------------------------------------------------
// plot_stream_format_classifier_core
// Names the data format of a plotter byte stream, or rejects it.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one raw stream byte per beat, req_tlast on the final byte.
//   rsp_* carries at most one result beat per stream: format, reject flag,
//   error code and the swapped-pair flag.
//   csr_* writes the largest block byte count a continuation header may
//   carry; write it only while no stream is in flight.
// Throughput: one req beat per cycle. The front part pairs and reorders bytes
// and the back parser takes up to two parsed bytes per cycle, so the input
// side only stalls when the slot queue fills.
// A deciding beat is written into the slot queue, then parsed into the output
// register that drives rsp.
// When the receiver stalls, the pending result holds and the parser keeps
// draining slots that produce no result; the queue then backs up into
// req_tready. After a result, bytes are dropped up to req_tlast, and every
// req_tlast restarts the stream parser.
// Reset clears the queue, the parser and the output, and sets the count
// limit to 32766.
// ----------------------------------------------------------------------------
module plot_stream_format_classifier_core #(
   parameter int QUEUE_DEPTH = psfc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // stream_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] format_code, [3] rejected,
                                    // [7:4] error_code, [8] swap_detected
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // max_block_count
);

   logic [15:0]               max_count_ff;
   logic                      push;
   psfc_pkg::queue_entry_type push_entry;
   logic                      queue_ready;
   logic                      pop_valid;
   psfc_pkg::queue_entry_type pop_entry;
   logic                      pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) max_count_ff <= psfc_pkg::MAX_BLOCK_COUNT_RESET;
      else if (csr_valid) max_count_ff <= csr_data;
   end

   psfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .push        (push),
      .push_entry  (push_entry),
      .queue_ready (queue_ready)
   );

   psfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (queue_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   psfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .max_count  (max_count_ff),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/psfc_front.sv -----
// ----------------------------------------------------------------------------
// psfc_front
// Input side: detects the swapped start, pairs and reorders bytes, and pushes
// zero, one or two parsed bytes per beat into the queue.
// ----------------------------------------------------------------------------
module psfc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] data_byte
   input  logic                      req_tlast,   // stream_last
   output logic                      push,
   output psfc_pkg::queue_entry_type push_entry,
   input  logic                      queue_ready
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] hold_ff, hold_in;
   logic       toggle_ff, toggle_in;
   logic       swap_ff, swap_in;
   logic       accept;
   logic       swap_now;

   assign req_tready = queue_ready;
   assign accept     = req_tvalid && queue_ready;
   assign push       = accept;

   always_comb begin
      phase_in  = phase_ff;
      hold_in   = hold_ff;
      toggle_in = toggle_ff;
      swap_in   = swap_ff;
      swap_now  = swap_ff;
      push_entry.byte0 = req_tdata;
      push_entry.byte1 = hold_ff;
      push_entry.count = 2'd0;
      case (phase_ff)
         psfc_pkg::FP_FIRST: begin
            hold_in  = req_tdata;
            phase_in = psfc_pkg::FP_SECOND;
         end
         psfc_pkg::FP_SECOND: begin
            swap_now  = (hold_ff == psfc_pkg::SWAP_LEAD) && (req_tdata == psfc_pkg::BLOCK_MARK);
            swap_in   = swap_now;
            toggle_in = 1'b0;
            phase_in  = psfc_pkg::FP_RUN;
            push_entry.count = 2'd2;
            if (!swap_now) begin
               push_entry.byte0 = hold_ff;
               push_entry.byte1 = req_tdata;
            end
         end
         default: begin
            if (swap_ff) begin
               if (!toggle_ff) begin
                  hold_in   = req_tdata;
                  toggle_in = 1'b1;
               end else begin
                  toggle_in = 1'b0;
                  push_entry.count = 2'd2;
               end
            end else begin
               push_entry.count = 2'd1;
            end
         end
      endcase
      push_entry.last = req_tlast;
      push_entry.swap = swap_now;
      // every stream end restarts the pairing
      if (req_tlast) begin
         phase_in  = psfc_pkg::FP_FIRST;
         toggle_in = 1'b0;
         swap_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= psfc_pkg::FP_FIRST;
         toggle_ff <= 1'b0;
         swap_ff   <= 1'b0;
         hold_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         toggle_ff <= toggle_in;
         swap_ff   <= swap_in;
         hold_ff   <= hold_in;
      end
   end

endmodule

// ----- rtl/psfc_queue.sv -----
// ----------------------------------------------------------------------------
// psfc_queue
// Small FIFO of parsed-byte slots between the front and back parts.
// ----------------------------------------------------------------------------
module psfc_queue #(
   parameter int DEPTH = psfc_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  psfc_pkg::queue_entry_type push_entry,
   output logic                      push_ready,
   output logic                      pop_valid,
   output psfc_pkg::queue_entry_type pop_entry,
   input  logic                      pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   psfc_pkg::queue_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ----- rtl/psfc_back.sv -----
// ----------------------------------------------------------------------------
// psfc_back
// Parser: runs up to two parsed bytes per slot through the frame and block
// parser and registers the one result of each stream.
// ----------------------------------------------------------------------------
module psfc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               max_count,
   input  logic                      pop_valid,
   input  psfc_pkg::queue_entry_type pop_entry,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata
);

   psfc_pkg::back_state_type state_ff, state_in;
   psfc_pkg::back_state_type step0, step1, step2;
   logic       emit;
   logic       out_free;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] fmt_ff;
   logic       err_flag_ff;
   logic [3:0] err_code_ff;
   logic       swap_ff;

   always_comb begin
      step0 = state_ff;
      if (pop_entry.count != 2'd0) step0 = psfc_pkg::feed(state_ff, pop_entry.byte0, max_count);
      step1 = step0;
      if (pop_entry.count == 2'd2) step1 = psfc_pkg::feed(step0, pop_entry.byte1, max_count);
      step2 = step1;
      if (!step1.decided && pop_entry.last)
         step2 = psfc_pkg::finish(step1, psfc_pkg::FMT_VECTOR, psfc_pkg::ERR_EARLY_END);
   end

   assign emit     = !state_ff.decided && step2.decided;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop      = pop_valid && (!emit || out_free);

   always_comb begin
      state_in = state_ff;
      if (pop) begin
         if (pop_entry.last) state_in = psfc_pkg::BACK_RESET;
         else if (!state_ff.decided) state_in = step2;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psfc_pkg::BACK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result while the receiver stalls
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         fmt_ff      <= (step2.res_err != psfc_pkg::ERR_NONE) ? psfc_pkg::FMT_VECTOR
                                                              : step2.res_fmt;
         err_flag_ff <= (step2.res_err != psfc_pkg::ERR_NONE);
         err_code_ff <= step2.res_err;
         swap_ff     <= pop_entry.swap;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, swap_ff, err_code_ff, err_flag_ff, fmt_ff};

endmodule

// ----- bench/psfc_verdict_pkg.sv -----
// ----------------------------------------------------------------------------
// psfc_verdict_pkg
// Scoreboard for the plot stream format classifier bench: a bit-level
// predictor of the stream parser and the queue of verdicts it owes.
// ----------------------------------------------------------------------------
package psfc_verdict_pkg;

   localparam logic [15:0] LIMIT_AT_RESET = 16'd32766;

   // frame sync 18 01 00 00 18 02 00 00, byte 0 in the lowest bits
   localparam logic [63:0] SYNC_BYTES = 64'h0000_0218_0000_0118;

   localparam logic [7:0]  MARK_BYTE  = 8'h18;
   localparam logic [7:0]  SWAP_FIRST = 8'h01;
   localparam logic [7:0]  TYPE_FSC   = 8'h01;
   localparam logic [7:0]  TYPE_COUNT = 8'h02;
   localparam logic [7:0]  TYPE_EOF   = 8'h03;
   localparam logic [15:0] FSC_WORD   = 16'h1802;
   localparam logic [15:0] COUNT_GFX  = 16'hffff;

   localparam logic [7:0] OP_VECTOR  = 8'h80;
   localparam logic [7:0] OP_RASTER  = 8'h81;
   localparam logic [7:0] OP_BLOCKED = 8'h82;
   localparam logic [7:0] OP_PACK16  = 8'h83;
   localparam logic [7:0] OP_PACK32  = 8'h84;
   localparam logic [7:0] OP_SKIP_C0 = 8'hc0;
   localparam logic [7:0] OP_SKIP_C5 = 8'hc5;
   localparam logic [7:0] OP_SKIP_C6 = 8'hc6;
   localparam logic [7:0] OP_SKIP_CC = 8'hcc;
   localparam logic [7:0] OP_IDLE_C2 = 8'hc2;
   localparam logic [7:0] OP_IDLE_C3 = 8'hc3;
   localparam logic [7:0] OP_IDLE_C4 = 8'hc4;

   localparam logic [2:0] F_VECTOR   = 3'd0;
   localparam logic [2:0] F_RASTER1D = 3'd1;
   localparam logic [2:0] F_BLOCKED  = 3'd4;
   localparam logic [2:0] F_PACK16   = 3'd5;
   localparam logic [2:0] F_PACK32   = 3'd6;
   localparam logic [2:0] F_GFX      = 3'd7;

   localparam logic [3:0] E_NONE      = 4'd0;
   localparam logic [3:0] E_SYNC      = 4'd1;
   localparam logic [3:0] E_HEADER    = 4'd2;
   localparam logic [3:0] E_SYNC_CONT = 4'd3;
   localparam logic [3:0] E_COUNT     = 4'd4;
   localparam logic [3:0] E_END_COUNT = 4'd5;
   localparam logic [3:0] E_COMMAND   = 4'd6;
   localparam logic [3:0] E_SPLIT     = 4'd7;
   localparam logic [3:0] E_EARLY_END = 4'd8;

   typedef enum logic [1:0] {PAIR_FIRST, PAIR_SECOND, PAIR_RUN} pair_stage_type;

   typedef enum logic [3:0] {
      PS_SYNC = 4'd2, PS_MARK, PS_TYPE, PS_FSC, PS_COUNT, PS_EOF, PS_CMD, PS_SKIP
   } parse_stage_type;

   typedef struct packed {
      logic [2:0] format_code;
      logic       rejected;
      logic [3:0] error_code;
      logic       swap_detected;
   } verdict_type;

   class verdict_scoreboard;
      logic [15:0]     count_limit;
      pair_stage_type  pair_stage;
      parse_stage_type stage;
      logic [2:0]      sync_pos;
      logic [2:0]      word_step;
      logic [15:0]     bytes_left;
      logic [15:0]     cmd_word;
      logic [7:0]      word_hi;
      logic [7:0]      held_byte;
      logic            held_valid;
      logic            swapped;
      logic            decided;
      logic [2:0]      fmt;
      logic [3:0]      err;
      verdict_type     verdicts_due[$];
      int              mismatches;
      int              verdicts_seen;
      int              beats_parsed;
      int              format_seen[8];
      int              error_seen[9];

      function new();
         count_limit   = LIMIT_AT_RESET;
         mismatches    = 0;
         verdicts_seen = 0;
         beats_parsed  = 0;
         restart();
      endfunction

      function void restart();
         pair_stage = PAIR_FIRST;
         stage      = PS_SYNC;
         sync_pos   = '0;
         word_step  = '0;
         bytes_left = '0;
         cmd_word   = '0;
         word_hi    = '0;
         held_byte  = '0;
         held_valid = 1'b0;
         swapped    = 1'b0;
         decided    = 1'b0;
         fmt        = F_VECTOR;
         err        = E_NONE;
      endfunction

      function void conclude(logic [2:0] f, logic [3:0] e);
         decided = 1'b1;
         fmt     = (e != E_NONE) ? F_VECTOR : f;
         err     = e;
      endfunction

      // pick the next step once a word or an operand byte is consumed
      function void settle();
         if (bytes_left == 16'd0) begin
            stage = PS_MARK;
         end else if (cmd_word[7:0] == 8'd0) begin
            if (bytes_left == 16'd1) begin
               conclude(F_VECTOR, E_SPLIT);
            end else begin
               stage     = PS_CMD;
               word_step = '0;
            end
         end else begin
            stage = PS_SKIP;
         end
      endfunction

      function void decode_command();
         logic [7:0] hi;
         logic [7:0] lo;
         hi = cmd_word[15:8];
         lo = cmd_word[7:0];
         case (hi)
            OP_VECTOR:  conclude(F_VECTOR, E_NONE);
            OP_RASTER: begin
               if (lo <= 8'd2) conclude(F_RASTER1D + lo[2:0], E_NONE);
               else conclude(F_VECTOR, E_COMMAND);
            end
            OP_BLOCKED: conclude(F_BLOCKED, E_NONE);
            OP_PACK16:  conclude(F_PACK16, E_NONE);
            OP_PACK32:  conclude(F_PACK32, E_NONE);
            OP_SKIP_C0, OP_SKIP_C5, OP_SKIP_C6, OP_SKIP_CC: settle();
            OP_IDLE_C2, OP_IDLE_C3, OP_IDLE_C4: begin
               if (lo != 8'd0) conclude(F_VECTOR, E_COMMAND);
               else settle();
            end
            default: conclude(F_VECTOR, E_COMMAND);
         endcase
      endfunction

      // one byte in parse order through frame, header and block logic
      function void parse_byte(logic [7:0] b);
         logic [15:0] w;
         if (decided) return;
         w = {word_hi, b};
         case (stage)
            PS_SYNC: begin
               if (b != SYNC_BYTES[8*sync_pos +: 8]) begin
                  conclude(F_VECTOR, E_SYNC);
               end else if (sync_pos == 3'd7) begin
                  sync_pos = '0;
                  stage    = PS_MARK;
               end else begin
                  sync_pos++;
               end
            end
            PS_MARK: begin
               if (b != MARK_BYTE) conclude(F_VECTOR, E_HEADER);
               else stage = PS_TYPE;
            end
            PS_TYPE: begin
               word_step = '0;
               if (b == TYPE_FSC) stage = PS_FSC;
               else if (b == TYPE_COUNT) stage = PS_COUNT;
               else if (b == TYPE_EOF) stage = PS_EOF;
               else conclude(F_VECTOR, E_HEADER);
            end
            PS_SKIP: begin
               cmd_word   = cmd_word - 16'd1;
               bytes_left = bytes_left - 16'd1;
               settle();
            end
            default: begin
               if (!word_step[0]) begin
                  word_hi = b;
                  word_step++;
               end else begin
                  case (stage)
                     PS_FSC: begin
                        if (w != ((word_step == 3'd3) ? FSC_WORD : 16'h0000)) begin
                           conclude(F_VECTOR, E_SYNC_CONT);
                        end else if (word_step >= 3'd5) begin
                           word_step = '0;
                           stage     = PS_MARK;
                        end else begin
                           word_step++;
                        end
                     end
                     PS_COUNT: begin
                        word_step = '0;
                        if (w == COUNT_GFX) begin
                           conclude(F_GFX, E_NONE);
                        end else if (w > count_limit) begin
                           conclude(F_VECTOR, E_COUNT);
                        end else begin
                           bytes_left = w;
                           settle();
                        end
                     end
                     PS_EOF: begin
                        word_step = '0;
                        if (w != 16'h0000) begin
                           conclude(F_VECTOR, E_END_COUNT);
                        end else begin
                           sync_pos = '0;
                           stage    = PS_SYNC;
                        end
                     end
                     default: begin
                        word_step  = '0;
                        cmd_word   = w;
                        bytes_left = bytes_left - 16'd2;
                        decode_command();
                     end
                  endcase
               end
            end
         endcase
      endfunction

      // accepted input beat; returns 1 when the beat was ignored
      function bit note_byte(logic [7:0] b, logic last);
         bit          was_decided;
         verdict_type v;
         was_decided = decided;
         if (!was_decided) begin
            beats_parsed++;
            case (pair_stage)
               PAIR_FIRST: begin
                  held_byte  = b;
                  pair_stage = PAIR_SECOND;
               end
               PAIR_SECOND: begin
                  swapped    = (held_byte == SWAP_FIRST) && (b == MARK_BYTE);
                  pair_stage = PAIR_RUN;
                  stage      = PS_SYNC;
                  sync_pos   = '0;
                  if (swapped) begin
                     parse_byte(b);
                     parse_byte(held_byte);
                  end else begin
                     parse_byte(held_byte);
                     parse_byte(b);
                  end
               end
               default: begin
                  if (!swapped) begin
                     parse_byte(b);
                  end else if (!held_valid) begin
                     held_byte  = b;
                     held_valid = 1'b1;
                  end else begin
                     held_valid = 1'b0;
                     parse_byte(b);
                     parse_byte(held_byte);
                  end
               end
            endcase
            if (!decided && last) conclude(F_VECTOR, E_EARLY_END);
            if (decided) begin
               v.format_code   = fmt;
               v.rejected      = (err != E_NONE);
               v.error_code    = err;
               v.swap_detected = swapped;
               verdicts_due.push_back(v);
               if (err == E_NONE) format_seen[fmt]++;
               else error_seen[err]++;
            end
         end
         if (last) restart();
         return was_decided;
      endfunction

      function void check_verdict(logic [15:0] beat);
         verdict_type v;
         if (verdicts_due.size() == 0) begin
            $error("result beat 0x%h arrived with no verdict pending", beat);
            mismatches++;
            return;
         end
         v = verdicts_due.pop_front();
         verdicts_seen++;
         if (beat[2:0] !== v.format_code) begin
            $error("format_code: expected %0d, actual %0d", v.format_code, beat[2:0]);
            mismatches++;
         end
         if (beat[3] !== v.rejected) begin
            $error("rejected: expected %0d, actual %0d", v.rejected, beat[3]);
            mismatches++;
         end
         if (beat[7:4] !== v.error_code) begin
            $error("error_code: expected %0d, actual %0d", v.error_code, beat[7:4]);
            mismatches++;
         end
         if (beat[8] !== v.swap_detected) begin
            $error("swap_detected: expected %0d, actual %0d", v.swap_detected, beat[8]);
            mismatches++;
         end
         if (beat[15:9] !== 7'd0) begin
            $error("tdata padding: expected 0, actual 0x%h", beat[15:9]);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ----- bench/tb_plot_stream_format_classifier_core.sv -----
// ----------------------------------------------------------------------------
// tb_plot_stream_format_classifier_core
// Feeds directed and random plotter byte streams, plain and pair-swapped,
// through the classifier under several count limits and back-pressure
// patterns, and checks every verdict beat against a bit-level predictor.
// ----------------------------------------------------------------------------
module tb_plot_stream_format_classifier_core;
   timeunit 1ns;
   timeprecision 1ps;

   import psfc_verdict_pkg::*;

   localparam int          RESET_CYCLES    = 12;
   localparam int          SETTLE_CYCLES   = 16;
   localparam int          DRAIN_GUARD     = 50000;
   localparam int          HOLD_CYCLES     = 250;
   localparam int          DIRECTED_CASES  = 25;
   localparam longint      TIMEOUT_NS      = 2_000_000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [7:0] data_byte
   logic        req_tlast  = 1'b0;   // stream_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [2:0] format_code, [3] rejected,
                                     // [7:4] error_code, [8] swap_detected
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = 16'h0000;  // max_block_count

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        rsp_hold       = 1'b0;

   logic [7:0]  stream_bytes[$];
   verdict_scoreboard sb;

   plot_stream_format_classifier_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= rsp_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.count_limit = csr_data;
         if (req_tvalid && req_tready) void'(sb.note_byte(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tdata);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d verdicts pending", sb.verdicts_due.size());
      $display("TB_ERROR");
      $finish;
   end

   function automatic void put(input logic [7:0] b);
      stream_bytes.push_back(b);
   endfunction

   function automatic void put_word(input logic [15:0] w);
      put(w[15:8]);
      put(w[7:0]);
   endfunction

   function automatic void put_sync();
      for (int i = 0; i < 8; i++) put(SYNC_BYTES[8*i +: 8]);
   endfunction

   function automatic void put_count(input logic [15:0] n);
      put(MARK_BYTE);
      put(TYPE_COUNT);
      put_word(n);
   endfunction

   function automatic void put_fsc();
      put(MARK_BYTE);
      put(TYPE_FSC);
      put_word(16'h0000);
      put_word(FSC_WORD);
      put_word(16'h0000);
   endfunction

   function automatic void put_eof();
      put(MARK_BYTE);
      put(TYPE_EOF);
      put_word(16'h0000);
      put_sync();
   endfunction

   // raw order of a swapped stream: every pair reversed, odd tail kept
   function automatic void swap_pairs();
      logic [7:0] t;
      for (int i = 0; i + 1 < stream_bytes.size(); i += 2) begin
         t                 = stream_bytes[i];
         stream_bytes[i]   = stream_bytes[i+1];
         stream_bytes[i+1] = t;
      end
   endfunction

   // mostly well-formed frames with random blocks, then a final count header: graphics, arbitrary or with a command
   function automatic void build_stream(input logic [15:0] limit);
      int unsigned headers, pending, left, cap, roll, idx;
      logic [7:0]  hi, lo;
      stream_bytes.delete();
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(1, 12)) put(8'($urandom));
         return;
      end
      put_sync();
      pending = 0;
      cap     = (limit < 16'd12) ? int'(limit) : 12;
      headers = $urandom_range(0, 3);
      repeat (headers) begin
         roll = $urandom_range(99);
         if (roll < 60) begin
            left = $urandom_range(0, cap);
            put_count(16'(left));
            while (left != 0) begin
               if (pending != 0) begin
                  put(8'($urandom));
                  pending--;
                  left--;
               end else if (left >= 2) begin
                  roll = $urandom_range(99);
                  if (roll < 70) begin
                     case ($urandom_range(3))
                        0: hi = OP_SKIP_C0;
                        1: hi = OP_SKIP_C5;
                        2: hi = OP_SKIP_C6;
                        default: hi = OP_SKIP_CC;
                     endcase
                     lo      = 8'($urandom_range(0, 5));
                     pending = lo;
                  end else if (roll < 92) begin
                     case ($urandom_range(2))
                        0: hi = OP_IDLE_C2;
                        1: hi = OP_IDLE_C3;
                        default: hi = OP_IDLE_C4;
                     endcase
                     lo = 8'h00;
                  end else begin
                     hi = 8'($urandom);
                     lo = 8'($urandom);
                  end
                  put(hi);
                  put(lo);
                  left -= 2;
               end else begin
                  put(8'($urandom));
                  left--;
               end
            end
         end else if (roll < 75) begin
            put_fsc();
         end else if (roll < 90) begin
            put_eof();
         end else begin
            put(MARK_BYTE);
            put(8'($urandom));
         end
      end
      roll = $urandom_range(99);
      if (roll < 6) begin
         put_count(COUNT_GFX);
      end else if (roll < 12) begin
         // arbitrary count: the stream ends long before such a block would
         put_count(16'($urandom));
         repeat ($urandom_range(0, 6)) put(8'($urandom));
      end else begin
         left = pending + 2 + $urandom_range(0, 2);
         put_count(16'(left));
         repeat (pending) put(8'($urandom));
         case ($urandom_range(5))
            0: hi = OP_VECTOR;
            1: hi = OP_RASTER;
            2: hi = OP_BLOCKED;
            3: hi = OP_PACK16;
            4: hi = OP_PACK32;
            default: hi = 8'($urandom);
         endcase
         lo = (hi == OP_RASTER) ? 8'($urandom_range(0, 3)) : 8'($urandom);
         put(hi);
         put(lo);
         repeat (left - pending - 2) put(8'($urandom));
      end
      if ($urandom_range(99) < 8) begin
         idx = $urandom_range(0, stream_bytes.size() - 1);
         stream_bytes[idx] = stream_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
      end
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, stream_bytes.size() - 1)) void'(stream_bytes.pop_back());
      end
      repeat ($urandom_range(0, 3)) put(8'($urandom));
      if ($urandom_range(99) < 40) swap_pairs();
   endfunction

   // starts and ends at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++) begin
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      end
   endtask

   task automatic write_limit(input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      while (sb.verdicts_due.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (sb.verdicts_due.size() != 0) begin
         $error("%0d verdicts never arrived", sb.verdicts_due.size());
         sb.mismatches++;
         sb.verdicts_due.delete();
      end
      // let bytes after the last verdict drain so the parser restarts
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic hold_results(input int cycles);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold = 1'b0;
   endtask

   // whole streams until about the given number of beats went out
   task automatic run_random(input int beats);
      int sent;
      sent = 0;
      while (sent < beats) begin
         build_stream(sb.count_limit);
         send_stream();
         sent += stream_bytes.size();
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic run_directed();
      for (int k = 0; k < DIRECTED_CASES; k++) begin
         stream_bytes.delete();
         put_sync();
         case (k)
            0:  begin put_count(16'd2); put_word(16'h8000); end
            1:  begin put_count(16'd2); put_word(16'h8100); end
            2:  begin put_count(16'd2); put_word(16'h8101); end
            3:  begin put_count(16'd2); put_word(16'h8102); end
            4:  begin put_count(16'd2); put_word(16'h8103); end   // bad raster subtype
            5:  begin put_count(16'd2); put_word(16'h82ff); end
            6:  begin put_count(16'd2); put_word(16'h8300); end
            7:  begin put_count(16'd2); put_word(16'h8400); end
            8:  put_count(COUNT_GFX);
            9:  put_count(16'h7fff);                             // one over the reset limit
            10: stream_bytes[3] = 8'hff;
            11: put(8'h17);
            12: begin put(MARK_BYTE); put(8'h04); end
            13: begin
               put_fsc();
               put(MARK_BYTE); put(TYPE_FSC); put_word(16'h0000); put_word(16'h1803);
            end
            14: begin put(MARK_BYTE); put(TYPE_EOF); put_word(16'h0001); end
            15: begin
               put_count(16'd0); put_eof();
               put_count(16'd4); put_word(16'hc200); put_word(16'h8000);
            end
            16: begin put_count(16'd2); put_word(16'h1234); end   // unknown command
            17: begin put_count(16'd2); put_word(16'hc305); end   // idle command with operand
            18: begin put_count(16'd3); put_word(16'hc200); put(8'h00); end  // split word
            19: begin
               // operands run past the block and the frame end
               put_count(16'd4); put_word(16'hc503); put(8'haa); put(8'hbb);
               put_eof();
               put_count(16'd3); put(8'hcc); put_word(16'h8400);
            end
            20: begin put_count(16'd10); put_word(16'hc000); end   // early end
            21: begin stream_bytes.delete(); put(8'h00); end
            22: begin put_count(16'd4); put_word(16'hc000); put_word(16'h8102); end
            23: begin put_count(16'd4); put(8'h80); end           // unpaired final byte
            default: begin
               put_count(16'd2); put_word(16'h8000);
               put(8'h00); put(8'hff); put(8'hff); put(8'h00);
            end
         endcase
         if (k == 22 || k == 23) swap_pairs();
         send_stream();
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int formats_hit, errors_hit;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed streams back to back; hold off the receiver long enough
      // for the slot queue to back up
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_limit(LIMIT_AT_RESET);
      fork
         hold_results(HOLD_CYCLES);
         run_directed();
      join
      wait_drained();

      write_limit(16'd65534);
      send_idle_pct = 88;
      run_random(40);
      wait_drained();

      write_limit(16'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 88;
      run_random(30);
      wait_drained();

      write_limit(16'd13);
      send_idle_pct  = 35;
      recv_stall_pct = 35;
      run_random(40);
      wait_drained();

      formats_hit = 0;
      errors_hit  = 0;
      for (int i = 0; i < 8; i++) if (sb.format_seen[i] != 0) formats_hit++;
      for (int i = 1; i < 9; i++) if (sb.error_seen[i] != 0) errors_hit++;
      $display("covered %0d verdicts over %0d parsed beats, plain and pair-swapped streams",
               sb.verdicts_seen, sb.beats_parsed);
      $display("%0d of 8 formats and %0d of 8 error kinds seen; four count limits, %0d-cycle hold-off",
               formats_hit, errors_hit, HOLD_CYCLES);
      if (sb.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
